// File: design/pwb_pkg.sv
// Shared types and constants for the proximity warning beeper.
`timescale 1ns / 1ps

package pwb_pkg;

  localparam int unsigned EchoW      = 16;
  localparam int unsigned HalfW      = 14;
  localparam int unsigned DistW      = 17;
  localparam int unsigned WarnW      = 10;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 16;

  // Echo ticks per centimetre of distance.
  localparam logic [5:0] EchoPerCm = 6'd58;

  // x / 29 == (x * RecipM) >> RecipShift for every x below 2^22.
  localparam int unsigned RecipShift = 27;
  localparam logic [22:0] RecipM     = 23'd4628198;

  localparam logic [WarnW-1:0] WarnReset     = 10'd50;
  localparam logic [EchoW-1:0] IntervalReset = 16'd200;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWarnDist = 1'b0,
    CfgTrigIntv = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    KindTick = 1'b0,
    KindEcho = 1'b1
  } kind_e;

  typedef struct packed {
    logic             kind;
    logic [EchoW-1:0] echo_ticks;
  } in_t;

  typedef struct packed {
    logic             led_on;
    logic             buzzer_on;
    logic             trigger_pulse;
    logic [DistW-1:0] distance_centi;
  } out_t;

  typedef struct packed {
    logic [EchoW-1:0] warn_thr;      // 58 * warning distance, in echo ticks
    logic [EchoW-1:0] trig_interval;
  } cfg_t;

  typedef struct packed {
    logic [HalfW-1:0] half_period;
    logic [DistW-1:0] distance;
  } scale_t;

endpackage

// File: design/pwb_echo_scale.sv
// Converts an echo width to a distance in hundredths of a cm and a beep half-period.
`timescale 1ns / 1ps

module pwb_echo_scale (
  input  logic [pwb_pkg::EchoW-1:0] echo_i,
  output pwb_pkg::scale_t           scale_o
);

  logic [21:0] x50;
  logic [18:0] x5;
  logic [44:0] prod_dist;
  logic [41:0] prod_half;

  // echo*100/58 == echo*50/29 and echo*10/58 == echo*5/29
  assign x50       = 22'(echo_i) * 22'd50;
  assign x5        = 19'(echo_i) * 19'd5;
  assign prod_dist = 45'(x50) * 45'(pwb_pkg::RecipM);
  assign prod_half = 42'(x5) * 42'(pwb_pkg::RecipM);

  assign scale_o.distance    = prod_dist[pwb_pkg::RecipShift +: pwb_pkg::DistW];
  assign scale_o.half_period = prod_half[pwb_pkg::RecipShift +: pwb_pkg::HalfW];

endmodule

// File: design/pwb_state.sv
// Beeper state: echo store, trigger and beep counters, buzzer level and result logic.
`timescale 1ns / 1ps

module pwb_state (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  pwb_pkg::in_t   item_i,
  input  pwb_pkg::cfg_t  cfg_i,
  output pwb_pkg::out_t  res_o
);

  logic [pwb_pkg::EchoW-1:0] last_echo_q, last_echo_d;
  logic [pwb_pkg::HalfW-1:0] half_q, half_d;
  logic [pwb_pkg::DistW-1:0] dist_q, dist_d;
  logic [pwb_pkg::EchoW-1:0] beep_cnt_q, beep_cnt_d;
  logic [pwb_pkg::EchoW-1:0] trig_cnt_q, trig_cnt_d;
  logic                      buzz_q, buzz_d;

  logic [pwb_pkg::EchoW-1:0] trig_inc, beep_inc;
  logic                      pulse, toggle, near, is_echo;
  pwb_pkg::scale_t           scale;

  pwb_echo_scale u_scale (
    .echo_i  (item_i.echo_ticks),
    .scale_o (scale)
  );

  assign is_echo  = (item_i.kind == pwb_pkg::KindEcho);
  assign trig_inc = trig_cnt_q + 16'd1;
  assign beep_inc = beep_cnt_q + 16'd1;
  assign pulse    = !is_echo && (trig_inc >= cfg_i.trig_interval);
  assign toggle   = !is_echo && (half_q != '0) && (beep_inc >= 16'(half_q));

  always_comb begin
    last_echo_d = last_echo_q;
    half_d      = half_q;
    dist_d      = dist_q;
    trig_cnt_d  = trig_cnt_q;
    beep_cnt_d  = beep_cnt_q;
    buzz_d      = buzz_q;
    if (is_echo) begin
      last_echo_d = item_i.echo_ticks;
      half_d      = scale.half_period;
      dist_d      = scale.distance;
    end else begin
      trig_cnt_d = pulse  ? '0 : trig_inc;
      beep_cnt_d = toggle ? '0 : beep_inc;
      buzz_d     = buzz_q ^ toggle;
    end
    near = (last_echo_d <= cfg_i.warn_thr);
    // hold the buzzer off while the target is far
    if (!near) begin
      buzz_d = 1'b0;
    end
  end

  assign res_o.led_on         = near;
  assign res_o.buzzer_on      = buzz_d;
  assign res_o.trigger_pulse  = pulse;
  assign res_o.distance_centi = dist_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_echo_q <= '0;
      half_q      <= '0;
      dist_q      <= '0;
      beep_cnt_q  <= 16'd1;
      trig_cnt_q  <= '0;
      buzz_q      <= 1'b0;
    end else if (fire_i) begin
      last_echo_q <= last_echo_d;
      half_q      <= half_d;
      dist_q      <= dist_d;
      beep_cnt_q  <= beep_cnt_d;
      trig_cnt_q  <= trig_cnt_d;
      buzz_q      <= buzz_d;
    end
  end

endmodule

// File: design/proximity_warning_beeper_core.sv
// Top level of the proximity warning beeper: request registers, configuration and handshakes.
//
// Usage: each input request is either a one millisecond tick (kind 0) or a completed
// echo width in microsecond timer ticks (kind 1). Every request gives exactly one
// result: LED and buzzer levels, a trigger pulse flag and the latest distance in
// hundredths of a cm.
// Channels: in_* and out_* move a request when valid is high and stall is low.
// Configuration writes go through cfg_*: index 0 is the warning distance in cm,
// index 1 the trigger interval in ticks; cfg_ready_o is always high. Writes must be
// made only while no request is in flight; the block does not enforce this.
// A request waits in the input register; its result is computed combinationally
// and loaded into the result register when that register can advance.
// Throughput: one request per cycle while the receiver does not stall; the counter
// update and echo scaling multiply sit in the single stage between the two registers.
// Reset marks both registers empty and sets warning distance 50 cm, interval 200 ticks.
// When the receiver stalls, the result register holds and the input register
// fills; the input side stalls once both hold a request.
`timescale 1ns / 1ps

module proximity_warning_beeper_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pwb_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pwb_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pwb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pwb_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic          in_v_q;
  pwb_pkg::in_t  in_q;
  logic          out_v_q;
  pwb_pkg::out_t out_q;
  pwb_pkg::cfg_t cfg_q;
  pwb_pkg::out_t res;
  logic          adv, fire;

  assign adv        = !out_v_q || !out_stall_i;
  assign fire       = in_v_q && adv;
  assign in_stall_o = in_v_q && !adv;
  assign cfg_ready_o = 1'b1;

  pwb_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warn_thr      <= 16'(pwb_pkg::WarnReset) * 16'(pwb_pkg::EchoPerCm);
      cfg_q.trig_interval <= pwb_pkg::IntervalReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pwb_pkg::CfgWarnDist: begin
          // keep the threshold in echo ticks so the compare needs no divide
          cfg_q.warn_thr <= 16'(cfg_data_i[pwb_pkg::WarnW-1:0]) * 16'(pwb_pkg::EchoPerCm);
        end
        pwb_pkg::CfgTrigIntv: begin
          cfg_q.trig_interval <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_v_q <= in_valid_i;
      end
      if (adv) begin
        out_v_q <= in_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule
